@@ rtl/vwsp_pkg.sv @@
package vwsp_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COORD_W = 12;
	localparam int unsigned PIXEL_W = 16;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned INDEX_W = 2;

	// Data word layout
	localparam int unsigned COUNT_LSB  = 24;
	localparam int unsigned SYNC_BIT   = 16;
	localparam int unsigned START_BIT  = 15;
	localparam int unsigned BLANK_BIT  = 9;

	localparam logic [COORD_W-1:0] COORD_MAX = '1;

	localparam logic [COORD_W-1:0] RST_MAX_COLUMN       = 12'd324;
	localparam logic [COORD_W-1:0] RST_MAX_LINE         = 12'd257;
	localparam logic [COORD_W-1:0] RST_SKIP_AFTER_LINE  = 12'd20;
	localparam logic [COORD_W-1:0] RST_FRAME_START_LINE = 12'd19;

	typedef enum logic [INDEX_W-1:0] {
		REG_MAX_COLUMN       = 2'd0,
		REG_MAX_LINE         = 2'd1,
		REG_SKIP_AFTER_LINE  = 2'd2,
		REG_FRAME_START_LINE = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [COORD_W-1:0] max_column;
		logic [COORD_W-1:0] max_line;
		logic [COORD_W-1:0] skip_after_line;
		logic [COORD_W-1:0] frame_start_line;
	} cfg_t;

	typedef struct packed {
		logic               write_enable;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] column;
		logic [PIXEL_W-1:0] pixel;
		logic               frame_done;
		logic               word_gap;
		logic               packet_gap;
	} result_t;

endpackage

@@ rtl/vwsp_if.sv @@
interface vwsp_word_if;
	import vwsp_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word;
	logic              is_header;

	modport source (output valid, word, is_header, input ready);
	modport sink   (input valid, word, is_header, output ready);
endinterface

interface vwsp_pixel_if;
	import vwsp_pkg::*;

	logic               valid;
	logic               ready;
	logic               write_enable;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] column;
	logic [PIXEL_W-1:0] pixel;
	logic               frame_done;
	logic               word_gap;
	logic               packet_gap;

	modport source (output valid, write_enable, row, column, pixel, frame_done, word_gap,
		packet_gap, input ready);
	modport sink   (input valid, write_enable, row, column, pixel, frame_done, word_gap,
		packet_gap, output ready);
endinterface

@@ rtl/vwsp_cfg_regs.sv @@
module vwsp_cfg_regs
	import vwsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [INDEX_W-1:0] wr_index,
	input  logic [COORD_W-1:0] wr_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_column       <= RST_MAX_COLUMN;
			cfg_q.max_line         <= RST_MAX_LINE;
			cfg_q.skip_after_line  <= RST_SKIP_AFTER_LINE;
			cfg_q.frame_start_line <= RST_FRAME_START_LINE;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_MAX_COLUMN:       cfg_q.max_column       <= wr_data;
				REG_MAX_LINE:         cfg_q.max_line         <= wr_data;
				REG_SKIP_AFTER_LINE:  cfg_q.skip_after_line  <= wr_data;
				REG_FRAME_START_LINE: cfg_q.frame_start_line <= wr_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/vwsp_tracker.sv @@
module vwsp_tracker
	import vwsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              advance,
	input  logic [WORD_W-1:0] word,
	input  logic              is_header,
	output result_t           res
);

	logic [WORD_W-1:0]  packet_counter_q;
	logic [COUNT_W-1:0] expected_count_q;
	logic               blanking_q;
	logic [COORD_W-1:0] line_q;
	logic [COORD_W-1:0] column_q;

	logic [COUNT_W-1:0] count;
	logic               sync;
	logic               blank_nx;
	logic [COORD_W-1:0] line_nx;
	logic [COORD_W-1:0] col_base;
	logic [COORD_W-1:0] column_nx;
	logic               skip;
	logic               in_bounds;

	always_comb begin
		count    = word[COUNT_LSB +: COUNT_W];
		sync     = word[SYNC_BIT];
		blank_nx = sync ? word[BLANK_BIT] : blanking_q;
		line_nx  = sync ? word[COORD_W-1:0] : line_q;
		col_base = sync ? '0 : column_q;
		// saturate at the top of the counter
		column_nx = blank_nx ? col_base
			: ((col_base == COORD_MAX) ? col_base : col_base + 1'b1);
		skip = line_nx > cfg.skip_after_line;
		in_bounds = (col_base != '0) && (col_base <= cfg.max_column)
			&& (line_nx != '0) && (line_nx <= cfg.max_line)
			&& (!skip || line_nx >= COORD_W'(2));

		res = '0;
		if (is_header) begin
			res.packet_gap = word != (packet_counter_q + 1'b1);
		end else begin
			res.word_gap   = count != expected_count_q;
			res.frame_done = sync && word[START_BIT] && (line_q != cfg.frame_start_line);
			if (!blank_nx && in_bounds) begin
				res.write_enable = 1'b1;
				res.row    = skip ? line_nx - COORD_W'(2) : line_nx - COORD_W'(1);
				res.column = col_base - 1'b1;
				res.pixel  = word[PIXEL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_counter_q <= '0;
			expected_count_q <= '0;
			blanking_q       <= 1'b0;
			line_q           <= '0;
			column_q         <= '0;
		end else if (advance) begin
			if (is_header) begin
				packet_counter_q <= word;
			end else begin
				expected_count_q <= count + 1'b1;
				blanking_q       <= blank_nx;
				line_q           <= line_nx;
				column_q         <= column_nx;
			end
		end
	end

endmodule

@@ rtl/video_word_stream_pixel_placer.sv @@
// An accepted word passes through the input register and then the result register
// to placement. Throughput: 1 word per cycle while placement stays ready; the tracker
// state updates as a word leaves the input register for the result register.
// Reset: arst_n clears both pipeline valids and the tracking state at once and
// loads the register defaults (324, 257, 20, 19).
module video_word_stream_pixel_placer
	import vwsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	vwsp_word_if.sink          capture,
	vwsp_pixel_if.source       placement,
	input  logic               wr_en,
	input  logic [INDEX_W-1:0] wr_index,
	input  logic [COORD_W-1:0] wr_data
);

	cfg_t cfg;

	// Input register: holds the word that the tracker works on.
	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              is_header_s1;

	// Result register: holds the finished word until placement takes it.
	logic    valid_s2;
	result_t res_s2;

	result_t res;
	logic    advance;

	vwsp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Advance the input word into the result register when that register is
	// empty or being drained this cycle; the tracker state moves with it.
	assign advance       = valid_s1 && (!valid_s2 || placement.ready);
	assign capture.ready = !valid_s1 || advance;

	vwsp_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.advance   (advance),
		.word      (word_s1),
		.is_header (is_header_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (capture.ready) begin
			valid_s1 <= capture.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (capture.valid && capture.ready) begin
			word_s1      <= capture.word;
			is_header_s1 <= capture.is_header;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (placement.ready) begin
			// drop the word once taken
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign placement.valid        = valid_s2;
	assign placement.write_enable = res_s2.write_enable;
	assign placement.row          = res_s2.row;
	assign placement.column       = res_s2.column;
	assign placement.pixel        = res_s2.pixel;
	assign placement.frame_done   = res_s2.frame_done;
	assign placement.word_gap     = res_s2.word_gap;
	assign placement.packet_gap   = res_s2.packet_gap;

`ifndef NO_ASSERTIONS
	// A header word only ever reports a packet gap.
	a_header_only_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.packet_gap |-> !res_s2.write_enable && !res_s2.word_gap
			&& !res_s2.frame_done)
		else $error("packet gap reported together with data word fields");

	// A sync word restarts the column, so it never carries a pixel write.
	a_sync_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.frame_done |-> !res_s2.write_enable)
		else $error("frame end and pixel write in the same word");

	// Coordinates and pixel stay zero without a write.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.write_enable |-> res_s2.row == '0 && res_s2.column == '0
			&& res_s2.pixel == '0)
		else $error("nonzero coordinates without a pixel write");

	// The tracker only advances when the result register can take the word.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !valid_s2 || placement.ready)
		else $error("result register overwritten while stalled");
`endif

endmodule
